/* hdl/mwm_pkg.sv */
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared widths, select codes, lane indexes and pipeline payload types for
// the mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

    // Fixed-point format: 1.0 is 1 << FRAC_BITS
    localparam int FRAC_BITS = 14;

    // Field widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int SEL_W = 2;
    localparam int LANES = 4;

    // Sum of three commands, its magnitude, and divider widths
    localparam int SUM_W = IN_W + 2;
    localparam int MAG_W = IN_W + 1;
    localparam int REM_W = MAG_W + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int STEP_W = $clog2(QW + 1);

    // Quotient bits resolved per divider stage
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Width for comparing the largest magnitude against 1.0
    localparam int CMP_W = (MAG_W > FRAC_BITS + 1) ? MAG_W : FRAC_BITS + 2;
    localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;

    // Signed wheel value before output saturation
    localparam int VAL_W = ((QW > MAG_W) ? QW : MAG_W) + 1;
    localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [VAL_W-1:0] SAT_LO = VAL_W'(-(1 << (OUT_W - 1)));

    // Bounds every delivered wheel value must respect
    localparam logic signed [OUT_W-1:0] OUT_HI_LIM = OUT_W'((FRAC_BITS < OUT_W - 1) ?
        (1 << FRAC_BITS) : ((1 << (OUT_W - 1)) - 1));
    localparam logic signed [OUT_W-1:0] OUT_LO_LIM = OUT_W'((FRAC_BITS < OUT_W - 1) ?
        -(1 << FRAC_BITS) : -(1 << (OUT_W - 1)));

    // Lane order
    localparam int LANE_LF = 0;
    localparam int LANE_LR = 1;
    localparam int LANE_RF = 2;
    localparam int LANE_RR = 3;

    // Wheel-select codes; the unused code behaves as all wheels
    typedef enum logic [SEL_W-1:0] {
        SEL_ALL   = 2'd0,
        SEL_REAR  = 2'd1,
        SEL_FRONT = 2'd2
    } wheel_sel_t;

    // Command set entering the pipeline
    typedef struct packed {
        logic signed [IN_W-1:0] drive;
        logic signed [IN_W-1:0] strafe;
        logic signed [IN_W-1:0] rotate;
        logic [SEL_W-1:0]       sel;
    } cmd_t;

    // Payload carried through the divider stages
    typedef struct packed {
        logic [SEL_W-1:0]            sel;
        logic                        scale;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]            dvsr;
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][QW-1:0]    quot;
        logic [STEP_W-1:0]           step;
    } div_t;

endpackage

/* hdl/mwm_cmd_if.sv */
// ----------------------------------------------------------------------------
// mwm_cmd_if
// Command channel: drive, strafe and rotate commands plus wheel select.
// ----------------------------------------------------------------------------
interface mwm_cmd_if;
    import mwm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] drive_cmd;
    logic signed [IN_W-1:0] strafe_cmd;
    logic signed [IN_W-1:0] rotate_cmd;
    logic [SEL_W-1:0]       wheel_select;

    modport source (
        output valid,
        output drive_cmd,
        output strafe_cmd,
        output rotate_cmd,
        output wheel_select,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive_cmd,
        input  strafe_cmd,
        input  rotate_cmd,
        input  wheel_select,
        output ready
    );

endinterface

/* hdl/mwm_wheel_if.sv */
// ----------------------------------------------------------------------------
// mwm_wheel_if
// Wheel channel: four signed motor drive values.
// ----------------------------------------------------------------------------
interface mwm_wheel_if;
    import mwm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_front_pwm;
    logic signed [OUT_W-1:0] left_rear_pwm;
    logic signed [OUT_W-1:0] right_front_pwm;
    logic signed [OUT_W-1:0] right_rear_pwm;

    modport source (
        output valid,
        output left_front_pwm,
        output left_rear_pwm,
        output right_front_pwm,
        output right_rear_pwm,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_front_pwm,
        input  left_rear_pwm,
        input  right_front_pwm,
        input  right_rear_pwm,
        output ready
    );

endinterface

/* hdl/mwm_mix.sv */
// ----------------------------------------------------------------------------
// mwm_mix
// Two pipeline stages: form the four wheel sums, then split them into sign
// and magnitude, find the largest magnitude and decide whether to rescale.
// ----------------------------------------------------------------------------
module mwm_mix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  mwm_pkg::cmd_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output mwm_pkg::div_t dn_data
);
    import mwm_pkg::*;

    logic                        s1_valid_reg;
    logic [LANES-1:0][SUM_W-1:0] s1_sum_reg;
    logic [LANES-1:0][SUM_W-1:0] s1_sum_next;
    logic [SEL_W-1:0]            s1_sel_reg;
    logic                        s1_ready;

    logic                        s2_valid_reg;
    div_t                        s2_data_reg;
    div_t                        s2_data_next;
    logic                        s2_ready;

    logic [SUM_W-1:0]            d_ext;
    logic [SUM_W-1:0]            s_ext;
    logic [SUM_W-1:0]            r_ext;
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
    logic [MAG_W-1:0]            max01;
    logic [MAG_W-1:0]            max23;
    logic [MAG_W-1:0]            max_all;

    // Stage enables: a stage loads when empty or when its successor moves
    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    // Stage 1: sums and differences of the commands
    always_comb
    begin
        d_ext = {{(SUM_W - IN_W){up_data.drive[IN_W-1]}}, up_data.drive};
        s_ext = {{(SUM_W - IN_W){up_data.strafe[IN_W-1]}}, up_data.strafe};
        r_ext = {{(SUM_W - IN_W){up_data.rotate[IN_W-1]}}, up_data.rotate};
        s1_sum_next[LANE_LF] = r_ext + d_ext + s_ext;
        s1_sum_next[LANE_LR] = r_ext + d_ext - s_ext;
        s1_sum_next[LANE_RF] = r_ext - d_ext + s_ext;
        s1_sum_next[LANE_RR] = r_ext - d_ext - s_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_sum_reg <= s1_sum_next;
            s1_sel_reg <= up_data.sel;
        end
    end

    // Stage 2: magnitudes, largest magnitude, rescale decision
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            neg[l] = s1_sum_reg[l][SUM_W-1];
            mag[l] = neg[l] ? MAG_W'(-s1_sum_reg[l]) : MAG_W'(s1_sum_reg[l]);
        end
        max01   = (mag[0] >= mag[1]) ? mag[0] : mag[1];
        max23   = (mag[2] >= mag[3]) ? mag[2] : mag[3];
        max_all = (max01 >= max23) ? max01 : max23;

        s2_data_next.sel   = s1_sel_reg;
        s2_data_next.scale = CMP_W'(max_all) > ONE_CMP;
        s2_data_next.neg   = neg;
        s2_data_next.mag   = mag;
        s2_data_next.dvsr  = max_all;
        for (int l = 0; l < LANES; l++)
        begin
            s2_data_next.rem[l]  = {1'b0, mag[l]};
            s2_data_next.quot[l] = '0;
        end
        s2_data_next.step  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_data_reg;

`ifndef SYNTHESIS
    // The divisor is the largest magnitude, so no lane may exceed it
    for (genvar l = 0; l < LANES; l++)
    begin : g_chk_max
        assert property (@(posedge clk) disable iff (!rst_n)
            dn_valid |-> dn_data.mag[l] <= dn_data.dvsr)
        else $error("wheel magnitude above selected maximum");
    end
`endif

endmodule

/* hdl/mwm_div_stage.sv */
// ----------------------------------------------------------------------------
// mwm_div_stage
// One stage of the restoring divider: resolves up to STEPS_PER_STAGE quotient bits of
// |w| * 1.0 / max for all four lanes, then registers the partial result.
// ----------------------------------------------------------------------------
module mwm_div_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  mwm_pkg::div_t up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output mwm_pkg::div_t dn_data
);
    import mwm_pkg::*;

    logic dn_valid_reg;
    div_t dn_data_reg;
    div_t dn_data_next;

    assign up_ready = !dn_valid_reg || dn_ready;

    // Compare, subtract, shift: one quotient bit per step, stop after QW bits
    always_comb
    begin
        logic [REM_W-1:0] diff;
        logic             qbit;

        diff = '0;
        qbit = 1'b0;
        dn_data_next = up_data;
        for (int j = 0; j < STEPS_PER_STAGE; j++)
        begin
            if (dn_data_next.step < STEP_W'(QW))
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    qbit = dn_data_next.rem[l] >= {1'b0, dn_data_next.dvsr};
                    diff = qbit ? dn_data_next.rem[l] - {1'b0, dn_data_next.dvsr}
                                : dn_data_next.rem[l];
                    dn_data_next.quot[l] = {dn_data_next.quot[l][QW-2:0], qbit};
                    dn_data_next.rem[l]  = {diff[REM_W-2:0], 1'b0};
                end
                dn_data_next.step = dn_data_next.step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            dn_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            dn_data_reg <= dn_data_next;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_data  = dn_data_reg;

`ifndef SYNTHESIS
    // Restoring division keeps the shifted remainder below twice the divisor
    for (genvar l = 0; l < LANES; l++)
    begin : g_chk_rem
        assert property (@(posedge clk) disable iff (!rst_n)
            dn_valid && dn_data.scale |-> dn_data.rem[l] < {dn_data.dvsr, 1'b0})
        else $error("divider remainder out of range");
    end
`endif

endmodule

/* hdl/mwm_out.sv */
// ----------------------------------------------------------------------------
// mwm_out
// Output stage: picks scaled or unscaled magnitude, restores the sign,
// saturates to the output width, applies wheel select and holds the result.
// ----------------------------------------------------------------------------
module mwm_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  mwm_pkg::div_t up_data,
    mwm_wheel_if.source   wheel
);
    import mwm_pkg::*;

    logic                        out_valid_reg;
    logic [LANES-1:0][OUT_W-1:0] out_pwm_reg;
    logic [LANES-1:0][OUT_W-1:0] out_pwm_next;

    logic [VAL_W-1:0]            val;
    logic signed [VAL_W-1:0]     res;

    assign up_ready = !out_valid_reg || wheel.ready;

    // Quotient never exceeds 1.0 since no lane exceeds the divisor
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            val = up_data.scale ? VAL_W'(up_data.quot[l]) : VAL_W'(up_data.mag[l]);
            res = up_data.neg[l] ? $signed(-val) : $signed(val);
            if (res > SAT_HI)
            begin
                out_pwm_next[l] = OUT_W'(SAT_HI);
            end
            else if (res < SAT_LO)
            begin
                out_pwm_next[l] = OUT_W'(SAT_LO);
            end
            else
            begin
                out_pwm_next[l] = OUT_W'(res);
            end
        end

        // Drop the unselected wheel pair
        case (up_data.sel)
            SEL_REAR:
            begin
                out_pwm_next[LANE_LF] = '0;
                out_pwm_next[LANE_RF] = '0;
            end
            SEL_FRONT:
            begin
                out_pwm_next[LANE_LR] = '0;
                out_pwm_next[LANE_RR] = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            out_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            out_pwm_reg <= out_pwm_next;
        end
    end

    assign wheel.valid           = out_valid_reg;
    assign wheel.left_front_pwm  = out_pwm_reg[LANE_LF];
    assign wheel.left_rear_pwm   = out_pwm_reg[LANE_LR];
    assign wheel.right_front_pwm = out_pwm_reg[LANE_RF];
    assign wheel.right_rear_pwm  = out_pwm_reg[LANE_RR];

`ifndef SYNTHESIS
    // Every delivered wheel value stays within +-1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        wheel.valid |->
            wheel.left_front_pwm  <= OUT_HI_LIM && wheel.left_front_pwm  >= OUT_LO_LIM &&
            wheel.left_rear_pwm   <= OUT_HI_LIM && wheel.left_rear_pwm   >= OUT_LO_LIM &&
            wheel.right_front_pwm <= OUT_HI_LIM && wheel.right_front_pwm >= OUT_LO_LIM &&
            wheel.right_rear_pwm  <= OUT_HI_LIM && wheel.right_rear_pwm  >= OUT_LO_LIM)
    else $error("wheel output beyond full scale");
`endif

endmodule

/* hdl/mecanum_wheel_mixer.sv */
// Each command set passes the mix stages, the divider stages and the output register.
// Throughput: one command set per cycle unless the wheel side stalls; the divider is split
// into DIV_STAGES registered stages of three quotient bits each, so nothing in the pipeline
// iterates. A stalled output only blocks the stages behind it once they are full.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// Mixes drive, strafe and rotate commands into four mecanum wheel values,
// rescales them when any exceeds 1.0, and applies the wheel-select code.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer (
    input  logic        clk,
    input  logic        rst_n,
    mwm_cmd_if.sink     cmd,
    mwm_wheel_if.source wheel
);
    import mwm_pkg::*;

    cmd_t                  cmd_data;
    logic                  mix_ready;
    logic [DIV_STAGES:0]   div_valid;
    logic [DIV_STAGES:0]   div_ready;
    div_t                  div_data [DIV_STAGES+1];

    // Gather the command fields
    assign cmd_data.drive  = cmd.drive_cmd;
    assign cmd_data.strafe = cmd.strafe_cmd;
    assign cmd_data.rotate = cmd.rotate_cmd;
    assign cmd_data.sel    = cmd.wheel_select;
    assign cmd.ready       = mix_ready;

    // Mixing and maximum search
    mwm_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cmd.valid),
        .up_ready (mix_ready),
        .up_data  (cmd_data),
        .dn_valid (div_valid[0]),
        .dn_ready (div_ready[0]),
        .dn_data  (div_data[0])
    );

    // Divider chain
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        mwm_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[g]),
            .up_ready (div_ready[g]),
            .up_data  (div_data[g]),
            .dn_valid (div_valid[g+1]),
            .dn_ready (div_ready[g+1]),
            .dn_data  (div_data[g+1])
        );
    end

    // Sign, saturation, wheel select and output register
    mwm_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (div_valid[DIV_STAGES]),
        .up_ready (div_ready[DIV_STAGES]),
        .up_data  (div_data[DIV_STAGES]),
        .wheel    (wheel)
    );

endmodule

/* dv/mecanum_wheel_mixer_test.sv */
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_test
// Streams command sets into the wheel mixer with random gaps on the command
// side and random stalls on the wheel side. It predicts the four wheel
// values of every accepted command set and compares each delivered set, in
// order, against that prediction.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mwm_pkg::*;

    localparam int         HALF_PERIOD  = 10;
    localparam int         RESET_CYCLES = 11;
    localparam int         RANDOM_SETS  = 1000;
    localparam int         LATENCY      = 2 + DIV_STAGES + 1;
    localparam int         DRAIN_CYCLES = 4 * LATENCY + 40;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;

    localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
    localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));

    typedef logic [LANES-1:0][OUT_W-1:0] wheel_vec_t;

    logic clk;
    logic rst_n;

    mwm_cmd_if   cmd_bus ();
    mwm_wheel_if wheel_bus ();

    mecanum_wheel_mixer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .wheel (wheel_bus)
    );

    cmd_t       cmd_pending[$];
    wheel_vec_t wheel_expected[$];
    int         cmds_queued;
    int         cmds_taken;
    int         fail_count;
    int         cycle_count;
    logic       cmd_xfer;
    int         cmd_gap;
    int         cmd_calm;
    int         stall_left;
    int         stall_calm;

    string lane_name[LANES] = '{"left_front_pwm", "left_rear_pwm",
                                "right_front_pwm", "right_rear_pwm"};

    // Clock generation
    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Saturate a value to a range
    function automatic longint sat(longint v, longint lo, longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Mix one command set into four wheel values
    function automatic wheel_vec_t mix_wheels(cmd_t c);
        longint     d;
        longint     s;
        longint     r;
        longint     peak;
        longint     w[LANES];
        wheel_vec_t res;
        d = $signed(c.drive);
        s = $signed(c.strafe);
        r = $signed(c.rotate);
        w[LANE_LF] = r + d + s;
        w[LANE_LR] = r + d - s;
        w[LANE_RF] = r - d + s;
        w[LANE_RR] = r - d - s;
        peak = 0;
        for (int i = 0; i < LANES; i++)
        begin
            if ((w[i] < 0 ? -w[i] : w[i]) > peak)
                peak = (w[i] < 0) ? -w[i] : w[i];
        end
        // Rescale by the largest magnitude; division truncates toward zero
        if (peak > ONE_Q)
        begin
            for (int i = 0; i < LANES; i++)
                w[i] = sat((w[i] * ONE_Q) / peak, -ONE_Q, ONE_Q);
        end
        // Drop the unselected pair
        if (c.sel == SEL_REAR)
        begin
            w[LANE_LF] = 0;
            w[LANE_RF] = 0;
        end
        else if (c.sel == SEL_FRONT)
        begin
            w[LANE_LR] = 0;
            w[LANE_RR] = 0;
        end
        for (int i = 0; i < LANES; i++)
            res[i] = OUT_W'(sat(w[i], OUT_MIN, OUT_MAX));
        return res;
    endfunction

    // Idle length: mostly short, a few long
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Append one command set to the pending queue
    task automatic queue_cmd(int d, int s, int r, logic [SEL_W-1:0] sel);
        cmd_t c;
        c.drive  = IN_W'(d);
        c.strafe = IN_W'(s);
        c.rotate = IN_W'(r);
        c.sel    = sel;
        cmd_pending.push_back(c);
        cmds_queued++;
    endtask

    // Random command value: mostly within +-1.0, some full range, some small
    function automatic int rand_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return int'($urandom_range(0, 32768)) - 16384;
        if (roll < 85)
            return int'($signed(16'($urandom)));
        return int'($urandom_range(0, 16384)) - 8192;
    endfunction

    // Drive the command channel at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_gap       = 0;
            cmd_calm      = 0;
        end
        else if (cmd_bus.valid && !cmd_xfer)
        begin
            // Hold the current set until it is taken
        end
        else if (cmd_gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_gap--;
        end
        else if (cmd_pending.size() > 0)
        begin
            cmd_t c;
            c = cmd_pending.pop_front();
            cmd_bus.valid        <= 1'b1;
            cmd_bus.drive_cmd    <= c.drive;
            cmd_bus.strafe_cmd   <= c.strafe;
            cmd_bus.rotate_cmd   <= c.rotate;
            cmd_bus.wheel_select <= c.sel;
            if (cmd_calm > 0)
            begin
                cmd_calm--;
                cmd_gap = 0;
            end
            else
            begin
                cmd_gap = pick_idle();
                if ($urandom_range(0, 63) == 0)
                    cmd_calm = $urandom_range(20, 80);
            end
        end
        else
        begin
            cmd_bus.valid <= 1'b0;
        end
    end

    // Stall the wheel channel at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_bus.ready <= 1'b0;
            stall_left      = 0;
            stall_calm      = 0;
        end
        else if (stall_left > 0)
        begin
            wheel_bus.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            wheel_bus.ready <= 1'b1;
            if (stall_calm > 0)
                stall_calm--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_idle();
            else if ($urandom_range(0, 63) == 0)
                stall_calm = $urandom_range(20, 80);
        end
    end

    // Predict on each command transfer and check each wheel transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_xfer <= 1'b0;
        end
        else
        begin
            cmd_xfer <= cmd_bus.valid && cmd_bus.ready;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                cmd_t c;
                c.drive  = cmd_bus.drive_cmd;
                c.strafe = cmd_bus.strafe_cmd;
                c.rotate = cmd_bus.rotate_cmd;
                c.sel    = cmd_bus.wheel_select;
                wheel_expected.push_back(mix_wheels(c));
                cmds_taken++;
            end
            if (wheel_bus.valid && wheel_bus.ready)
            begin
                wheel_vec_t got;
                wheel_vec_t want;
                got[LANE_LF] = wheel_bus.left_front_pwm;
                got[LANE_LR] = wheel_bus.left_rear_pwm;
                got[LANE_RF] = wheel_bus.right_front_pwm;
                got[LANE_RR] = wheel_bus.right_rear_pwm;
                if (wheel_expected.size() == 0)
                begin
                    $error("wheel transfer with no command set outstanding");
                    fail_count++;
                end
                else
                begin
                    want = wheel_expected.pop_front();
                    for (int i = 0; i < LANES; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $error("%s: expected %0d, actual %0d", lane_name[i],
                                   $signed(want[i]), $signed(got[i]));
                            fail_count++;
                        end
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.drive_cmd    = '0;
        cmd_bus.strafe_cmd   = '0;
        cmd_bus.rotate_cmd   = '0;
        cmd_bus.wheel_select = SEL_ALL;
        wheel_bus.ready      = 1'b0;
        cmds_queued          = 0;
        cmds_taken           = 0;
        fail_count           = 0;
        cycle_count          = 0;

        // Directed: extremes, every select code, scaling edges
        queue_cmd(0, 0, 0, SEL_ALL);
        queue_cmd(16384, 0, 0, SEL_ALL);
        queue_cmd(-16384, 0, 0, SEL_ALL);
        queue_cmd(0, 16384, 0, SEL_REAR);
        queue_cmd(0, 0, -16384, SEL_FRONT);
        queue_cmd(8192, 8192, 0, SEL_ALL);
        queue_cmd(8192, 8193, 0, SEL_ALL);
        queue_cmd(16384, 16384, 16384, SEL_ALL);
        queue_cmd(-16384, -16384, -16384, SEL_REAR);
        queue_cmd(32767, 32767, 32767, SEL_ALL);
        queue_cmd(-32768, -32768, -32768, SEL_ALL);
        queue_cmd(32767, -32768, 32767, SEL_FRONT);
        queue_cmd(-32768, 32767, -32768, SEL_UNUSED);
        queue_cmd(1000, -2000, 3000, SEL_UNUSED);
        queue_cmd(16384, 16384, -16384, SEL_FRONT);
        queue_cmd(-1, -1, -1, SEL_ALL);
        queue_cmd(1, 0, 0, SEL_REAR);
        queue_cmd(12000, -9000, 5000, SEL_ALL);
        queue_cmd(16384, -16384, 16384, SEL_REAR);
        queue_cmd(-16384, 16384, 16384, SEL_FRONT);

        // Random command sets
        for (int n = 0; n < RANDOM_SETS; n++)
            queue_cmd(rand_cmd(), rand_cmd(), rand_cmd(), SEL_W'($urandom_range(0, 3)));

        // Release reset at a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every set to be taken and every result to arrive
        while (cmds_taken < cmds_queued)
            @(posedge clk);
        while (wheel_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* mecanum_wheel_mixer.f */
hdl/mwm_pkg.sv
hdl/mwm_cmd_if.sv
hdl/mwm_wheel_if.sv
hdl/mwm_mix.sv
hdl/mwm_div_stage.sv
hdl/mwm_out.sv
hdl/mecanum_wheel_mixer.sv
dv/mecanum_wheel_mixer_test.sv
